/* sv/jsu_pkg.sv */
// Shared types, codes and helper functions of the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    localparam int MaxRes = 6;

    // decoder modes
    localparam logic [2:0] M_NORMAL  = 3'd0;
    localparam logic [2:0] M_ESC     = 3'd1;
    localparam logic [2:0] M_HEX1    = 3'd2;
    localparam logic [2:0] M_HIGH    = 3'd3;
    localparam logic [2:0] M_HIGH_BS = 3'd4;
    localparam logic [2:0] M_HEX2    = 3'd5;

    // result kinds
    localparam logic [2:0] K_BYTE       = 3'd0;
    localparam logic [2:0] K_END        = 3'd1;
    localparam logic [2:0] K_UNTERM_STR = 3'd2;
    localparam logic [2:0] K_UNTERM_ESC = 3'd3;
    localparam logic [2:0] K_UNTERM_U   = 3'd4;
    localparam logic [2:0] K_BAD_HEX    = 3'd5;
    localparam logic [2:0] K_BAD_ESC    = 3'd6;

    // characters
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChB      = 8'h62;
    localparam logic [7:0] ChF      = 8'h66;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChU      = 8'h75;

    localparam logic [15:0] SurHiMin = 16'hD800;
    localparam logic [15:0] SurHiMax = 16'hDBFF;
    localparam logic [15:0] SurLoMin = 16'hDC00;
    localparam logic [15:0] SurLoMax = 16'hDFFF;
    localparam logic [20:0] SupBase  = 21'h10000;
    localparam logic [20:0] ReplCp   = 21'h00FFFD;

    localparam logic [7:0] Lead2    = 8'hC0;
    localparam logic [7:0] Lead3    = 8'hE0;
    localparam logic [7:0] Lead4    = 8'hF0;
    localparam logic [7:0] ContMark = 8'h80;
    localparam logic [7:0] ContMask = 8'h3F;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  hex_count;
        logic [15:0] hex_accum;
        logic [9:0]  high_unit;
    } t_state;

    localparam t_state StateIdle = '{mode: M_NORMAL, hex_count: 2'd0,
                                     hex_accum: 16'd0, high_unit: 10'd0};

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
    } t_result;

    typedef t_result [MaxRes-1:0] t_res_vec;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } t_utf8;

    // {valid, digit}; valid low for a non-hex character
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 e;
        e = '0;
        if (cp <= 21'h7F) begin
            e.len  = 3'd1;
            e.b[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            e.len  = 3'd2;
            e.b[0] = Lead2 | {3'b000, cp[10:6]};
            e.b[1] = ContMark | ({2'b00, cp[5:0]} & ContMask);
        end else if (cp <= 21'hFFFF) begin
            e.len  = 3'd3;
            e.b[0] = Lead3 | {4'b0000, cp[15:12]};
            e.b[1] = ContMark | ({2'b00, cp[11:6]} & ContMask);
            e.b[2] = ContMark | ({2'b00, cp[5:0]} & ContMask);
        end else begin
            e.len  = 3'd4;
            e.b[0] = Lead4 | {5'b00000, cp[20:18]};
            e.b[1] = ContMark | ({2'b00, cp[17:12]} & ContMask);
            e.b[2] = ContMark | ({2'b00, cp[11:6]} & ContMask);
            e.b[3] = ContMark | ({2'b00, cp[5:0]} & ContMask);
        end
        return e;
    endfunction

endpackage

`default_nettype wire

/* sv/json_string_unescape_utf8_top.sv */
// JSON string body unescaper with UTF-8 output, one byte a word in and out.
// The first result word of an item is registered and shows in the cycle after the item
// is taken. The single result buffer drains one word a cycle while the output is ready;
// a new input byte is taken only once the last held word leaves. Input bytes that give
// one result or none stream at one per cycle while the output is ready.
// Reset: synchronous, active low; clears the decoder state and empties the buffer.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top import jsu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_text,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_kind,
    output logic            o_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready
);

    t_state     r_state;
    t_state     n_state;
    logic [2:0] num;
    t_res_vec   res;
    logic       accept;

    assign accept = i_in_valid && o_in_ready;

    jsu_decode u_decode (
        .i_state       (r_state),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_next        (n_state),
        .o_num         (num),
        .o_res         (res)
    );

    jsu_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && num != 3'd0),
        .i_num       (num),
        .i_res       (res),
        .i_pop_ready (i_out_ready),
        .o_can_load  (o_in_ready),
        .o_valid     (o_out_valid),
        .o_data      (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateIdle;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* sv/jsu_decode.sv */
// Next-state and result-word logic for one input byte of the string body.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode import jsu_pkg::*; (
    input  wire t_state     i_state,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_text,
    output t_state          o_next,
    output logic [2:0]      o_num,
    output t_res_vec        o_res
);

    localparam t_utf8 ReplEnc = utf8_enc(ReplCp);

    t_state          nxt;
    logic            pre;
    logic            use_cp;
    logic [20:0]     cp_sel;
    logic            tok_valid;
    t_result         tok;
    logic            do_norm;
    logic            do_esc;
    logic [4:0]      hv;
    logic [15:0]     v;
    t_utf8           enc;
    t_result [3:0]   main_w;
    logic [2:0]      main_len;

    assign hv  = hex_val(i_in_byte);
    assign v   = {i_state.hex_accum[11:0], hv[3:0]};
    assign enc = utf8_enc(cp_sel);

    always_comb begin
        nxt       = i_state;
        pre       = 1'b0;
        use_cp    = 1'b0;
        cp_sel    = '0;
        tok_valid = 1'b0;
        tok       = '0;
        do_norm   = 1'b0;
        do_esc    = 1'b0;

        if (i_end_of_text) begin
            nxt       = StateIdle;
            tok_valid = 1'b1;
            unique case (i_state.mode)
                M_ESC:          tok.kind = K_UNTERM_ESC;
                M_HEX1, M_HEX2: tok.kind = K_UNTERM_U;
                M_HIGH: begin
                    pre      = 1'b1;
                    tok.kind = K_UNTERM_STR;
                end
                M_HIGH_BS: begin
                    pre      = 1'b1;
                    tok.kind = K_UNTERM_ESC;
                end
                default:        tok.kind = K_UNTERM_STR;
            endcase
        end else begin
            unique case (i_state.mode)
                M_ESC: do_esc = 1'b1;
                M_HEX1, M_HEX2: begin
                    if (!hv[4]) begin
                        tok_valid = 1'b1;
                        tok.kind  = K_BAD_HEX;
                        nxt       = StateIdle;
                    end else if (i_state.hex_count != 2'd3) begin
                        nxt.hex_accum = v;
                        nxt.hex_count = i_state.hex_count + 2'd1;
                    end else begin
                        nxt.hex_count = 2'd0;
                        nxt.hex_accum = 16'd0;
                        nxt.mode      = M_NORMAL;
                        if (i_state.mode == M_HEX1) begin
                            if (v >= SurHiMin && v <= SurHiMax) begin
                                nxt.high_unit = v[9:0];
                                nxt.mode      = M_HIGH;
                            end else begin
                                use_cp = 1'b1;
                                cp_sel = {5'd0, v};
                            end
                        end else begin
                            use_cp        = 1'b1;
                            nxt.high_unit = 10'd0;
                            if (v >= SurLoMin && v <= SurLoMax) begin
                                cp_sel = SupBase + {1'b0, i_state.high_unit, v[9:0]};
                            end else begin
                                // mismatched pair: replacement, then the unit alone
                                pre    = 1'b1;
                                cp_sel = {5'd0, v};
                            end
                        end
                    end
                end
                M_HIGH: begin
                    if (i_in_byte == ChBslash) begin
                        nxt.mode = M_HIGH_BS;
                    end else begin
                        pre           = 1'b1;
                        nxt.high_unit = 10'd0;
                        do_norm       = 1'b1;
                    end
                end
                M_HIGH_BS: begin
                    if (i_in_byte == ChU) begin
                        nxt.mode      = M_HEX2;
                        nxt.hex_count = 2'd0;
                        nxt.hex_accum = 16'd0;
                    end else begin
                        pre           = 1'b1;
                        nxt.high_unit = 10'd0;
                        do_esc        = 1'b1;
                    end
                end
                default: do_norm = 1'b1;
            endcase

            if (do_norm) begin
                if (i_in_byte == ChQuote) begin
                    tok_valid = 1'b1;
                    tok.kind  = K_END;
                    nxt       = StateIdle;
                end else if (i_in_byte == ChBslash) begin
                    nxt.mode = M_ESC;
                end else begin
                    tok_valid = 1'b1;
                    tok       = '{data: i_in_byte, kind: K_BYTE};
                    nxt.mode  = M_NORMAL;
                end
            end

            if (do_esc) begin
                nxt.mode  = M_NORMAL;
                tok_valid = 1'b1;
                tok.kind  = K_BYTE;
                unique case (i_in_byte)
                    ChQuote, ChBslash, ChSlash: tok.data = i_in_byte;
                    ChB: tok.data = 8'h08;
                    ChF: tok.data = 8'h0C;
                    ChN: tok.data = 8'h0A;
                    ChR: tok.data = 8'h0D;
                    ChT: tok.data = 8'h09;
                    ChU: begin
                        tok_valid     = 1'b0;
                        nxt.mode      = M_HEX1;
                        nxt.hex_count = 2'd0;
                        nxt.hex_accum = 16'd0;
                    end
                    default: begin
                        tok.kind = K_BAD_ESC;
                        nxt      = StateIdle;
                    end
                endcase
            end
        end
    end

    // main part: an encoded code point, a single word, or nothing
    always_comb begin
        main_w   = '0;
        main_len = 3'd0;
        if (use_cp) begin
            main_len = enc.len;
            for (int k = 0; k < 4; k++) begin
                main_w[k] = '{data: enc.b[k], kind: K_BYTE};
            end
        end else if (tok_valid) begin
            main_len  = 3'd1;
            main_w[0] = tok;
        end
    end

    // place the optional replacement character ahead of the main part
    always_comb begin
        int idx;
        for (int i = 0; i < MaxRes; i++) begin
            idx = pre ? i - 3 : i;
            if (pre && i < 3) begin
                o_res[i] = '{data: ReplEnc.b[i], kind: K_BYTE};
            end else if (idx >= 0 && idx < 4) begin
                o_res[i] = main_w[idx[1:0]];
            end else begin
                o_res[i] = '0;
            end
        end
    end

    assign o_num  = pre ? main_len + 3'd3 : main_len;
    assign o_next = nxt;

endmodule

`default_nettype wire

/* sv/jsu_outbuf.sv */
// Result buffer: holds the words of one item and drains them one a cycle while the output is ready.
`timescale 1ns / 1ps
`default_nettype none

module jsu_outbuf import jsu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [2:0] i_num,
    input  wire t_res_vec   i_res,
    input  wire logic       i_pop_ready,
    output logic            o_can_load,
    output logic            o_valid,
    output logic [7:0]      o_data,
    output logic [2:0]      o_kind,
    output logic            o_last
);

    t_res_vec   r_res;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_valid    = (r_cnt != 3'd0);
    assign pop        = o_valid && i_pop_ready;
    // free when empty, or once the last held word leaves this cycle
    assign o_can_load = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_pop_ready);
    assign o_data     = r_res[0].data;
    assign o_kind     = r_res[0].kind;
    assign o_last     = (r_cnt == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_num;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end else if (pop) begin
            for (int i = 0; i < MaxRes - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
            r_res[MaxRes-1] <= '0;
        end
    end

endmodule

`default_nettype wire

/* sv/jsu_checker.sv */
// Port-level checks of the unescaper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker import jsu_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic [2:0] o_kind,
    input wire logic       o_last,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_kind) && $stable(o_last))
        else $error("stalled result word changed");

    // status words carry no byte
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != K_BYTE |-> o_out_byte == 8'd0)
        else $error("status word with nonzero byte");

    // an end or error word always closes its item
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != K_BYTE |-> o_last)
        else $error("status word not last");

    // no new word is taken while more than one result is pending
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input taken while results pending");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_byte  (o_out_byte),
    .o_kind      (o_kind),
    .o_last      (o_last),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);

`default_nettype wire
